@@ hw/rtl/rbr_pkg.sv @@
package rbr_pkg;

   // Default framebuffer geometry in pixels.
   localparam int FB_WIDTH_DEF  = 1920;
   localparam int FB_HEIGHT_DEF = 1080;

   // Field widths.
   localparam int COORD_W   = 13;
   localparam int RADIUS_W  = 12;
   localparam int COLOR_W   = 32;
   localparam int OFFSET_W  = 23;
   localparam int DIST_W    = 14;
   localparam int REQ_W     = 8;
   localparam int RSP_W     = 56;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RECT_X        = 3'd0,
      CSR_RECT_Y        = 3'd1,
      CSR_RECT_WIDTH    = 3'd2,
      CSR_RECT_HEIGHT   = 3'd3,
      CSR_BORDER_WIDTH  = 3'd4,
      CSR_CORNER_RADIUS = 3'd5,
      CSR_BORDER_COLOR  = 3'd6,
      CSR_SHAPE_MODE    = 3'd7
   } csr_index_type;

   // Shape mode codes.
   localparam logic SHAPE_SQUARE  = 1'b0;
   localparam logic SHAPE_ROUNDED = 1'b1;

endpackage

@@ hw/rtl/rect_border_rasterizer.sv @@
// Channel | Dir | Ports                          | Contents
// req     | in  | req_tvalid/tready/tdata[7:0]   | start_req
// rsp     | out | rsp_tvalid/tready/tdata[55:0]  | byte_offset, pixel_value
//         |     | rsp_tuser[0], rsp_tlast        | write_enable, scan_done
// csr     | in  | csr_valid/ready/index/data     | register writes, always ready
//
// One position is accepted per clock while the output side is not stalled. Each
// transfer passes through four register stages (input, corner distances, squares,
// result) in that order.
// Each stage holds its data while the stage after it is full and stalled.
// Reset is synchronous and clears the scan position and all stage valid bits.
module rect_border_rasterizer #(
   parameter int FB_WIDTH  = rbr_pkg::FB_WIDTH_DEF,
   parameter int FB_HEIGHT = rbr_pkg::FB_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rbr_pkg::REQ_W-1:0]       req_tdata,   // [0] start_req, rest zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rbr_pkg::RSP_W-1:0]       rsp_tdata,   // [22:0] byte_offset,
                                                        // [54:23] pixel_value, [55] zero
   output logic                            rsp_tuser,   // [0] write_enable
   output logic                            rsp_tlast,   // scan_done
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rbr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rbr_pkg::CSR_DAT_W-1:0]   csr_data
);

   localparam int CW = rbr_pkg::COORD_W;
   localparam int DW = rbr_pkg::DIST_W;
   localparam int RW = rbr_pkg::RADIUS_W;

   // Configuration registers.
   logic signed [CW-1:0]         rect_x_ff, rect_y_ff;
   logic [CW-1:0]                rect_w_ff, rect_h_ff, border_w_ff;
   logic [RW-1:0]                radius_ff;
   logic [rbr_pkg::COLOR_W-1:0]  color_ff;
   logic                         mode_ff;

   // Scan position.
   logic [CW-1:0] row_ff, row_in, col_ff, col_in;
   logic          scanning_ff, scanning_in;

   // Stage valid bits and handshake.
   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic rdy3, rdy2, rdy1;
   logic req_xfer;

   // Stage 1 payload.
   logic          act1_ff, done1_ff;
   logic [CW-1:0] row1_ff, col1_ff;
   logic          act1_in, done1_in;
   logic [CW-1:0] row1_in, col1_in;

   // Stage 2 payload.
   logic          act2_ff, done2_ff, sq2_ff, kv2_ff;
   logic [DW-1:0] dx2_ff, dy2_ff;
   logic [12:0]   up2_ff;
   logic [11:0]   k2_ff, px2_ff, py2_ff;
   logic          act2_in, sq2_in, kv2_in;
   logic [DW-1:0] dx2_in, dy2_in;
   logic [12:0]   up2_in;
   logic [11:0]   k2_in, px2_in, py2_in;

   // Stage 3 payload.
   logic          act3_ff, done3_ff, sq3_ff, kv3_ff;
   logic [27:0]   dxx3_ff, dyy3_ff;
   logic [25:0]   upp3_ff;
   logic [23:0]   kk3_ff;
   logic [11:0]   px3_ff;
   logic [24:0]   pyw3_ff;

   // Result register.
   logic                          we_ff, done_ff;
   logic [rbr_pkg::OFFSET_W-1:0]  off_ff;
   logic [rbr_pkg::COLOR_W-1:0]   pix_ff;
   logic                          we_in;
   logic [rbr_pkg::OFFSET_W-1:0]  off_in;

   // Distance from a position into the corner band of one axis.
   function automatic logic [DW-1:0] corner_dist(input logic [CW-1:0] p,
                                                 input logic [CW-1:0] size,
                                                 input logic [RW-1:0] r);
      logic [DW-1:0] p14, r14, s14, d;
      p14 = {1'b0, p};
      r14 = {2'b00, r};
      s14 = {1'b0, size};
      if (p14 < r14) begin
         d = r14 - p14;
      end else if (p14 + r14 >= s14) begin
         d = p14 + r14 + 14'd1 - s14;
      end else begin
         d = '0;
      end
      return d;
   endfunction

   // Configuration writes.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_x_ff   <= '0;
         rect_y_ff   <= '0;
         rect_w_ff   <= '0;
         rect_h_ff   <= '0;
         border_w_ff <= 13'd1;
         radius_ff   <= '0;
         color_ff    <= '0;
         mode_ff     <= rbr_pkg::SHAPE_SQUARE;
      end else if (csr_valid && csr_ready) begin
         case (rbr_pkg::csr_index_type'(csr_index))
            rbr_pkg::CSR_RECT_X:        rect_x_ff   <= csr_data[CW-1:0];
            rbr_pkg::CSR_RECT_Y:        rect_y_ff   <= csr_data[CW-1:0];
            rbr_pkg::CSR_RECT_WIDTH:    rect_w_ff   <= csr_data[CW-1:0];
            rbr_pkg::CSR_RECT_HEIGHT:   rect_h_ff   <= csr_data[CW-1:0];
            rbr_pkg::CSR_BORDER_WIDTH:  border_w_ff <= csr_data[CW-1:0];
            rbr_pkg::CSR_CORNER_RADIUS: radius_ff   <= csr_data[RW-1:0];
            rbr_pkg::CSR_BORDER_COLOR:  color_ff    <= csr_data;
            rbr_pkg::CSR_SHAPE_MODE:    mode_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Each stage moves on when the stage after it is empty or moving.
   assign rdy3       = !vo_ff || rsp_tready;
   assign rdy2       = !v3_ff || rdy3;
   assign rdy1       = !v2_ff || rdy2;
   assign req_tready = !v1_ff || rdy1;
   assign req_xfer   = req_tvalid && req_tready;

   // Scan sequencing on each accepted transfer.
   always_comb begin
      logic          start, empty, scan_now, col_end, last;
      logic [CW-1:0] cur_row, cur_col;
      start    = req_tdata[0];
      empty    = (rect_w_ff == '0) || (rect_h_ff == '0);
      cur_row  = start ? '0 : row_ff;
      cur_col  = start ? '0 : col_ff;
      scan_now = start ? !empty : scanning_ff;
      col_end  = ({1'b0, cur_col} + 14'd1) >= {1'b0, rect_w_ff};
      last     = col_end && (({1'b0, cur_row} + 14'd1) >= {1'b0, rect_h_ff});

      act1_in     = scan_now;
      done1_in    = scan_now ? last : (start && empty);
      row1_in     = cur_row;
      col1_in     = cur_col;
      row_in      = cur_row;
      col_in      = cur_col;
      scanning_in = scan_now;
      if (scan_now) begin
         if (last) begin
            scanning_in = 1'b0;
            row_in      = '0;
            col_in      = '0;
         end else if (col_end) begin
            col_in = '0;
            row_in = cur_row + 13'd1;
         end else begin
            col_in = cur_col + 13'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         scanning_ff <= 1'b0;
      end else if (req_xfer) begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         scanning_ff <= scanning_in;
      end
   end

   // Stage 2 logic: edge test, corner distances, radius bounds and clipping.
   always_comb begin
      logic                in_range, clip_ok;
      logic signed [14:0]  px, py;
      logic [12:0]         two_r;
      logic [DW-1:0]       knum;
      in_range = (row1_ff < rect_h_ff) && (col1_ff < rect_w_ff);
      sq2_in   = (row1_ff < border_w_ff)
              || (({1'b0, row1_ff} + {1'b0, border_w_ff}) >= {1'b0, rect_h_ff})
              || (col1_ff < border_w_ff)
              || (({1'b0, col1_ff} + {1'b0, border_w_ff}) >= {1'b0, rect_w_ff});
      dx2_in   = corner_dist(col1_ff, rect_w_ff, radius_ff);
      dy2_in   = corner_dist(row1_ff, rect_h_ff, radius_ff);
      up2_in   = {1'b0, radius_ff} + 13'd1;
      two_r    = {radius_ff, 1'b0};
      kv2_in   = two_r > border_w_ff;
      knum     = {1'b0, two_r} - {1'b0, border_w_ff} + 14'd1;
      k2_in    = knum[12:1];
      px       = 15'(rect_x_ff) + $signed({2'b00, col1_ff});
      py       = 15'(rect_y_ff) + $signed({2'b00, row1_ff});
      clip_ok  = !px[14] && (px[13:0] < 14'(FB_WIDTH))
              && !py[14] && (py[13:0] < 14'(FB_HEIGHT));
      px2_in   = px[11:0];
      py2_in   = py[11:0];
      act2_in  = act1_ff && in_range && clip_ok;
   end

   // Result logic: exact squared-distance tests and the framebuffer offset.
   always_comb begin
      logic [28:0] s;
      logic        rnd, draw;
      logic [24:0] idx;
      s     = {1'b0, dxx3_ff} + {1'b0, dyy3_ff};
      rnd   = (s < {3'b000, upp3_ff}) && !(kv3_ff && (s < {5'b00000, kk3_ff}));
      draw  = (mode_ff == rbr_pkg::SHAPE_ROUNDED) ? rnd : sq3_ff;
      we_in = act3_ff && draw;
      idx   = pyw3_ff + {13'd0, px3_ff};
      off_in = we_in ? {idx[20:0], 2'b00} : '0;
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (req_tready) v1_ff <= req_xfer;
         if (rdy1)       v2_ff <= v1_ff;
         if (rdy2)       v3_ff <= v2_ff;
         if (rdy3)       vo_ff <= v3_ff;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         act1_ff  <= act1_in;
         done1_ff <= done1_in;
         row1_ff  <= row1_in;
         col1_ff  <= col1_in;
      end
      if (rdy1 && v1_ff) begin
         act2_ff  <= act2_in;
         done2_ff <= done1_ff;
         sq2_ff   <= sq2_in;
         kv2_ff   <= kv2_in;
         dx2_ff   <= dx2_in;
         dy2_ff   <= dy2_in;
         up2_ff   <= up2_in;
         k2_ff    <= k2_in;
         px2_ff   <= px2_in;
         py2_ff   <= py2_in;
      end
      if (rdy2 && v2_ff) begin
         act3_ff  <= act2_ff;
         done3_ff <= done2_ff;
         sq3_ff   <= sq2_ff;
         kv3_ff   <= kv2_ff;
         dxx3_ff  <= 28'(dx2_ff) * 28'(dx2_ff);
         dyy3_ff  <= 28'(dy2_ff) * 28'(dy2_ff);
         upp3_ff  <= 26'(up2_ff) * 26'(up2_ff);
         kk3_ff   <= 24'(k2_ff) * 24'(k2_ff);
         px3_ff   <= px2_ff;
         pyw3_ff  <= 25'(py2_ff) * 25'(FB_WIDTH);
      end
      if (rdy3 && v3_ff) begin
         we_ff   <= we_in;
         done_ff <= done3_ff;
         off_ff  <= off_in;
         pix_ff  <= we_in ? color_ff : '0;
      end
   end

   // Result channel.
   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = {1'b0, pix_ff, off_ff};
   assign rsp_tuser  = we_ff;
   assign rsp_tlast  = done_ff;

   // An idle scanner always sits at the top-left.
   a_idle_origin : assert property (@(posedge clock) disable iff (reset)
      !scanning_ff |-> (row_ff == '0) && (col_ff == '0))
      else $error("idle scanner not at origin");

   // A result without a write carries no offset and no color.
   a_quiet_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("non-writing result carries data");

   // An accepted transfer always lands in the input stage.
   a_input_capture : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> v1_ff)
      else $error("accepted transfer lost");

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rbr_pkg::*;

   localparam int ITEM_TARGET    = 1600;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int FB_W           = FB_WIDTH_DEF;
   localparam int FB_H           = FB_HEIGHT_DEF;

   // One framebuffer write as the block reports it.
   typedef struct packed {
      logic        we;
      logic [22:0] offset;
      logic [31:0] color;
      logic        done;
   } pixel_write_type;

   // Tracks the scan position and the register copies, and predicts the
   // framebuffer write for every accepted position.
   class border_write_scoreboard;
      logic signed [12:0] rect_x;
      logic signed [12:0] rect_y;
      logic [12:0]        rect_w;
      logic [12:0]        rect_h;
      logic [12:0]        border_w;
      logic [11:0]        radius;
      logic [31:0]        color;
      logic               shape;
      logic [12:0]        row_pos;
      logic [12:0]        col_pos;
      bit                 active;
      pixel_write_type    pending_writes[$];
      int                 errors;

      function new();
         rect_x   = '0;
         rect_y   = '0;
         rect_w   = '0;
         rect_h   = '0;
         border_w = 13'd1;
         radius   = '0;
         color    = '0;
         shape    = SHAPE_SQUARE;
         row_pos  = '0;
         col_pos  = '0;
         active   = 1'b0;
         errors   = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_RECT_X:        rect_x   = value[12:0];
            CSR_RECT_Y:        rect_y   = value[12:0];
            CSR_RECT_WIDTH:    rect_w   = value[12:0];
            CSR_RECT_HEIGHT:   rect_h   = value[12:0];
            CSR_BORDER_WIDTH:  border_w = value[12:0];
            CSR_CORNER_RADIUS: radius   = value[11:0];
            CSR_BORDER_COLOR:  color    = value;
            CSR_SHAPE_MODE:    shape    = value[0];
            default: ;
         endcase
      endfunction

      // Distance into a corner region along one axis, zero on the straight part.
      function longint unsigned corner_gap(longint unsigned pos, longint unsigned size,
                                           longint unsigned r);
         if (pos < r)
            return r - pos;
         if (pos + r >= size)
            return pos + r + 1 - size;
         return 0;
      endfunction

      // Border test in wide unsigned arithmetic, so oversized borders and radii
      // behave like the unsigned hardware comparisons.
      function bit on_border(longint unsigned row, longint unsigned col);
         longint unsigned w, h, bw, r, dx, dy, sq, outer, inner;
         w  = rect_w;
         h  = rect_h;
         bw = border_w;
         r  = radius;
         if (row >= h || col >= w)
            return 1'b0;
         if (shape == SHAPE_SQUARE)
            return row < bw || row + bw >= h || col < bw || col + bw >= w;
         dx    = corner_gap(col, w, r);
         dy    = corner_gap(row, h, r);
         sq    = dx * dx + dy * dy;
         outer = r + 1;
         if (sq >= outer * outer)
            return 1'b0;
         // The inner edge is radius minus half the border, doubled to stay integer.
         if (2 * r > bw) begin
            inner = (2 * r - bw + 1) / 2;
            if (sq < inner * inner)
               return 1'b0;
         end
         return 1'b1;
      endfunction

      // Called for every accepted position transfer.
      function void note_position(bit start);
         pixel_write_type exp;
         int              px;
         int              py;
         int unsigned     pix_index;
         bit              col_end;
         bit              row_end;
         exp = '0;
         if (start) begin
            row_pos = '0;
            col_pos = '0;
            if (rect_w == 0 || rect_h == 0) begin
               // Empty rectangle: the scan ends at once.
               active   = 1'b0;
               exp.done = 1'b1;
               pending_writes.push_back(exp);
               return;
            end
            active = 1'b1;
         end
         if (active) begin
            if (on_border(row_pos, col_pos)) begin
               px = int'(rect_x);
               px += int'(col_pos);
               py = int'(rect_y);
               py += int'(row_pos);
               // Clip against the framebuffer.
               if (px >= 0 && px < FB_W && py >= 0 && py < FB_H) begin
                  pix_index  = unsigned'(px + py * FB_W);
                  pix_index  = pix_index * 4;
                  exp.we     = 1'b1;
                  exp.offset = pix_index[22:0];
                  exp.color  = color;
               end
            end
            col_end = int'(col_pos) + 1 >= int'(rect_w);
            row_end = int'(row_pos) + 1 >= int'(rect_h);
            if (col_end && row_end) begin
               exp.done = 1'b1;
               active   = 1'b0;
               row_pos  = '0;
               col_pos  = '0;
            end else if (col_end) begin
               col_pos = '0;
               row_pos = row_pos + 13'd1;
            end else begin
               col_pos = col_pos + 13'd1;
            end
         end
         pending_writes.push_back(exp);
      endfunction

      // Called for every accepted result transfer.
      function void check_write(logic [RSP_W-1:0] data, logic user, logic last_flag);
         pixel_write_type got;
         pixel_write_type exp;
         got.we     = user;
         got.offset = data[22:0];
         got.color  = data[54:23];
         got.done   = last_flag;
         if (pending_writes.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         exp = pending_writes.pop_front();
         if (got !== exp) begin
            errors++;
            if (got.we !== exp.we)
               $display("%0t: write_enable expected %0b, actual %0b", $time, exp.we, got.we);
            if (got.offset !== exp.offset)
               $display("%0t: byte_offset expected %0d, actual %0d", $time,
                        exp.offset, got.offset);
            if (got.color !== exp.color)
               $display("%0t: pixel_value expected %h, actual %h", $time,
                        exp.color, got.color);
            if (got.done !== exp.done)
               $display("%0t: scan_done expected %0b, actual %0b", $time, exp.done, got.done);
         end
      endfunction

      function int pending();
         return pending_writes.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   border_write_scoreboard sb;
   int                     burst_left = 0;
   int                     items_sent = 0;
   int                     idle_cycles = 0;
   logic [7:0]             stall_phase = '0;

   rect_border_rasterizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Result side: check each transfer and stall on a rotating pattern of
   // always ready, random, periodic and mostly stalled stretches.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_write(rsp_tdata, rsp_tuser, rsp_tlast);
      stall_phase <= stall_phase + 8'd1;
      case (stall_phase[7:6])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 1) == 1);
         2'd2: rsp_tready <= (stall_phase[2:0] < 3'd3);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Position source: bursts of random length separated by random gaps.
   task automatic send_request(input bit start);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W-1){1'b0}}, start};
      do @(posedge clock); while (!req_tready);
      sb.note_position(start);
      burst_left--;
      items_sent++;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
   endtask

   task automatic apply_setting(input int x, input int y, input int w, input int h,
                                input int bw, input int r, input logic [31:0] color,
                                input logic mode);
      write_csr(CSR_RECT_X, x);
      write_csr(CSR_RECT_Y, y);
      write_csr(CSR_RECT_WIDTH, w);
      write_csr(CSR_RECT_HEIGHT, h);
      write_csr(CSR_BORDER_WIDTH, bw);
      write_csr(CSR_CORNER_RADIUS, r);
      write_csr(CSR_BORDER_COLOR, color);
      write_csr(CSR_SHAPE_MODE, {31'd0, mode});
      csr_valid <= 1'b0;
   endtask

   // Stop sending and wait until every predicted write has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Rectangle origin: full range, just off the low edge, at the far edge,
   // or well inside the framebuffer.
   function automatic int pick_origin(int fb_size);
      case ($urandom_range(0, 4))
         0: return int'($urandom_range(0, 8191)) - 4096;
         1: return -int'($urandom_range(0, 8));
         2: return fb_size - int'($urandom_range(0, 10));
         default: return int'($urandom_range(0, fb_size - 20));
      endcase
   endfunction

   // One random setting followed by a scan, mostly complete, with rare restarts.
   task automatic random_phase();
      int w;
      int h;
      int bw;
      int r;
      int n;
      int pick;
      bit fresh;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 14);
         h = (w == 0) ? $urandom_range(0, 14) : 0;
      end else if (pick == 1) begin
         w = $urandom_range(1, 4096);
         h = $urandom_range(1, 4096);
      end else begin
         w = $urandom_range(1, 14);
         h = $urandom_range(1, 14);
      end
      case ($urandom_range(0, 9))
         0: bw = $urandom_range(0, 4096);
         1: bw = 0;
         default: bw = $urandom_range(1, 4);
      endcase
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2048) : $urandom_range(0, 8);
      apply_setting(pick_origin(FB_W), pick_origin(FB_H), w, h, bw, r, $urandom,
                    $urandom_range(0, 1));
      // Some phases carry on with the scan left over from the last setting.
      fresh = ($urandom_range(0, 4) != 0);
      if (w * h > 0 && w * h <= 200)
         n = w * h - 1 + $urandom_range(0, 3);
      else
         n = $urandom_range(10, 60);
      if (fresh)
         send_request(1'b1);
      repeat (n) send_request($urandom_range(0, 39) == 0);
      drain();
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset setting: idle step, empty rectangle, idle again.
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);
      drain();

      // Small square outline clipped at the left and top edges.
      apply_setting(-1, -1, 3, 3, 1, 0, 32'hA5C3_0F81, SHAPE_SQUARE);
      send_request(1'b1);
      repeat (9) send_request(1'b0);
      drain();

      // Rounded outline clipped at the right and bottom edges, restarted mid-scan.
      apply_setting(FB_W - 3, FB_H - 3, 5, 5, 1, 2, 32'h1234_5678, SHAPE_ROUNDED);
      send_request(1'b1);
      repeat (6) send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);
      drain();

      // Extreme register values, border as wide as the rectangle and corner diameter equal to it.
      apply_setting(-4096, 4095, 4096, 4096, 4096, 2048, 32'hFFFF_FFFF, SHAPE_ROUNDED);
      send_request(1'b1);
      send_request(1'b0);
      drain();

      while (items_sent < ITEM_TARGET)
         random_phase();

      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/rbr_pkg.sv
hw/rtl/rect_border_rasterizer.sv
tb/sv/tb_top.sv
